@@ src/binary_response_frame_parser_core_macros.svh @@
// Assertion macros for the frame parser RTL.
`ifndef BINARY_RESPONSE_FRAME_PARSER_CORE_MACROS_SVH
`define BINARY_RESPONSE_FRAME_PARSER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define BRFP_ASSERT_IMP(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define BRFP_ASSERT_NXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) else $error(msg);

`endif

@@ src/brfp_pkg.sv @@
// Types and constants of the binary response frame parser.
package brfp_pkg;

   localparam logic [7:0] MAGIC_A       = 8'h42;
   localparam logic [7:0] MAGIC_B       = 8'h48;
   localparam logic [7:0] VERSION_OK    = 8'h01;
   localparam logic [7:0] TYPE_RESPONSE = 8'h02;
   localparam logic [7:0] TYPE_ERROR    = 8'h03;
   localparam logic [7:0] ID_CONT_LEN   = 8'h01;
   localparam logic [7:0] ID_CONT_TYPE  = 8'h02;

   localparam logic [3:0] HDR_BYTES = 4'd12;
   localparam logic [3:0] HDR_LAST  = 4'd11;
   localparam logic [3:0] POS_TYPE  = 4'd3;
   localparam logic [3:0] POS_FLAGS = 4'd4;
   localparam logic [3:0] POS_LEN0  = 4'd5;
   localparam logic [3:0] POS_LEN2  = 4'd7;
   localparam logic [3:0] POS_SID0  = 4'd8;
   localparam logic [3:0] POS_MAGB  = 4'd1;
   localparam logic [3:0] POS_VER   = 4'd2;

   // payload phases
   localparam logic [3:0] PH_ST_HI   = 4'd0;
   localparam logic [3:0] PH_ST_LO   = 4'd1;
   localparam logic [3:0] PH_COUNT   = 4'd2;
   localparam logic [3:0] PH_ID      = 4'd3;
   localparam logic [3:0] PH_VL_HI   = 4'd4;
   localparam logic [3:0] PH_VL_LO   = 4'd5;
   localparam logic [3:0] PH_VALUE   = 4'd6;
   localparam logic [3:0] PH_BODY    = 4'd7;
   localparam logic [3:0] PH_ERRPAY  = 4'd8;
   localparam logic [3:0] PH_DISCARD = 4'd9;

   // byte kinds
   localparam logic [3:0] KIND_HEADER  = 4'd0;
   localparam logic [3:0] KIND_STATUS  = 4'd1;
   localparam logic [3:0] KIND_COUNT   = 4'd2;
   localparam logic [3:0] KIND_HDR_ID  = 4'd3;
   localparam logic [3:0] KIND_VAL_LEN = 4'd4;
   localparam logic [3:0] KIND_VALUE   = 4'd5;
   localparam logic [3:0] KIND_BODY    = 4'd6;
   localparam logic [3:0] KIND_ERR_PAY = 4'd7;
   localparam logic [3:0] KIND_DISCARD = 4'd8;
   localparam logic [3:0] KIND_HALTED  = 4'd9;

   // error codes
   localparam logic [2:0] ERR_NONE     = 3'd0;
   localparam logic [2:0] ERR_MAGIC    = 3'd1;
   localparam logic [2:0] ERR_VERSION  = 3'd2;
   localparam logic [2:0] ERR_SHORT    = 3'd3;
   localparam logic [2:0] ERR_TRUNC_HD = 3'd4;
   localparam logic [2:0] ERR_TRUNC_VL = 3'd5;
   localparam logic [2:0] ERR_STREAM   = 3'd6;
   localparam logic [2:0] ERR_TYPE     = 3'd7;

   // header names
   localparam logic [1:0] NAME_CONT_LEN  = 2'd0;
   localparam logic [1:0] NAME_CONT_TYPE = 2'd1;
   localparam logic [1:0] NAME_UNKNOWN   = 2'd2;

   // configuration register addresses
   localparam logic [2:0] CSR_EXP_STREAM = 3'd0;

   typedef struct packed {
      logic [3:0]  header_position;
      logic [7:0]  type_reg;
      logic [7:0]  flags_reg;
      logic [23:0] payload_left;
      logic [31:0] stream_reg;
      logic [3:0]  payload_phase;
      logic [7:0]  headers_left;
      logic [15:0] value_left;
      logic [15:0] status_reg;
      logic [1:0]  name_reg;
      logic [2:0]  pending_error;
      logic        halted;
   } state_type;

   typedef struct packed {
      logic [3:0]  byte_kind;
      logic [7:0]  data_byte;
      logic [1:0]  header_name;
      logic [15:0] status_code;
      logic [7:0]  frame_kind;
      logic [31:0] frame_stream;
      logic        last_of_frame;
      logic [2:0]  error_code;
      logic        end_stream_missing;
   } result_type;

endpackage

@@ src/brfp_step.sv @@
// Per-word parse step: next parser state and the word's classification.
module brfp_step (
   input  brfp_pkg::state_type  cur,
   input  logic [31:0]          expected_stream,
   input  logic [7:0]           rx_byte,
   output brfp_pkg::state_type  nxt,
   output brfp_pkg::result_type res
);

   logic [3:0]  kind;
   logic [2:0]  err;
   logic        last;
   logic        esm;
   logic        bad_hdr;
   logic        mismatch;
   logic [31:0] new_stream;
   logic [23:0] pl_m1;
   logic [7:0]  hl_m1;
   logic [15:0] vl_m1;
   logic [15:0] vl_full;

   always_comb begin
      nxt        = cur;
      kind       = brfp_pkg::KIND_HEADER;
      err        = brfp_pkg::ERR_NONE;
      last       = 1'b0;
      esm        = 1'b0;
      bad_hdr    = 1'b0;
      mismatch   = 1'b0;
      new_stream = {cur.stream_reg[23:0], rx_byte};
      pl_m1      = cur.payload_left - 24'd1;
      hl_m1      = cur.headers_left - 8'd1;
      vl_m1      = cur.value_left - 16'd1;
      vl_full    = {cur.value_left[15:8], rx_byte};

      if (cur.halted) begin
         kind = brfp_pkg::KIND_HALTED;
         err  = cur.pending_error;
      end else if (cur.header_position < brfp_pkg::HDR_BYTES) begin
         if (cur.header_position == 4'd0) begin
            nxt.type_reg      = '0;
            nxt.flags_reg     = '0;
            nxt.payload_left  = '0;
            nxt.stream_reg    = '0;
            nxt.status_reg    = '0;
            nxt.name_reg      = '0;
            nxt.pending_error = brfp_pkg::ERR_NONE;
            nxt.headers_left  = '0;
            nxt.value_left    = '0;
            nxt.payload_phase = brfp_pkg::PH_ST_HI;
         end
         bad_hdr = (cur.header_position == 4'd0 && rx_byte != brfp_pkg::MAGIC_A) ||
                   (cur.header_position == brfp_pkg::POS_MAGB &&
                    rx_byte != brfp_pkg::MAGIC_B) ||
                   (cur.header_position == brfp_pkg::POS_VER &&
                    rx_byte != brfp_pkg::VERSION_OK);
         if (bad_hdr) begin
            nxt.pending_error   = (cur.header_position == brfp_pkg::POS_VER) ?
                                  brfp_pkg::ERR_VERSION : brfp_pkg::ERR_MAGIC;
            nxt.halted          = 1'b1;
            nxt.header_position = 4'd0;
            err                 = nxt.pending_error;
            last                = 1'b1;
         end else begin
            if (cur.header_position == brfp_pkg::POS_TYPE) begin
               nxt.type_reg = rx_byte;
            end else if (cur.header_position == brfp_pkg::POS_FLAGS) begin
               nxt.flags_reg = rx_byte;
            end else if (cur.header_position >= brfp_pkg::POS_LEN0 &&
                         cur.header_position <= brfp_pkg::POS_LEN2) begin
               nxt.payload_left = {cur.payload_left[15:0], rx_byte};
            end else if (cur.header_position >= brfp_pkg::POS_SID0) begin
               nxt.stream_reg = new_stream;
            end

            if (cur.header_position == brfp_pkg::HDR_LAST) begin
               mismatch            = new_stream != expected_stream;
               nxt.header_position = brfp_pkg::HDR_BYTES;
               if (mismatch) begin
                  nxt.payload_phase = brfp_pkg::PH_DISCARD;
                  nxt.pending_error = brfp_pkg::ERR_STREAM;
               end else if (cur.type_reg == brfp_pkg::TYPE_RESPONSE) begin
                  if (cur.payload_left < 24'd3) begin
                     nxt.payload_phase = brfp_pkg::PH_DISCARD;
                     nxt.pending_error = brfp_pkg::ERR_SHORT;
                  end else begin
                     nxt.payload_phase = brfp_pkg::PH_ST_HI;
                  end
               end else if (cur.type_reg == brfp_pkg::TYPE_ERROR) begin
                  nxt.payload_phase = brfp_pkg::PH_ERRPAY;
               end else begin
                  nxt.payload_phase = brfp_pkg::PH_DISCARD;
                  nxt.pending_error = brfp_pkg::ERR_TYPE;
               end
               // empty payload closes the frame on the last header word
               if (cur.payload_left == 24'd0) begin
                  last                = 1'b1;
                  err                 = nxt.pending_error;
                  esm                 = !mismatch && !cur.flags_reg[0];
                  nxt.header_position = 4'd0;
                  nxt.payload_phase   = brfp_pkg::PH_ST_HI;
               end
            end else begin
               nxt.header_position = cur.header_position + 4'd1;
            end
         end
      end else begin
         unique case (cur.payload_phase)
            brfp_pkg::PH_ST_HI: begin
               kind              = brfp_pkg::KIND_STATUS;
               nxt.status_reg    = {rx_byte, 8'd0};
               nxt.payload_phase = brfp_pkg::PH_ST_LO;
            end
            brfp_pkg::PH_ST_LO: begin
               kind              = brfp_pkg::KIND_STATUS;
               nxt.status_reg    = {cur.status_reg[15:8], rx_byte};
               nxt.payload_phase = brfp_pkg::PH_COUNT;
            end
            brfp_pkg::PH_COUNT: begin
               kind              = brfp_pkg::KIND_COUNT;
               nxt.headers_left  = rx_byte;
               nxt.payload_phase = (rx_byte != 8'd0) ? brfp_pkg::PH_ID : brfp_pkg::PH_BODY;
            end
            brfp_pkg::PH_ID: begin
               if (cur.payload_left < 24'd3) begin
                  kind              = brfp_pkg::KIND_DISCARD;
                  nxt.pending_error = brfp_pkg::ERR_TRUNC_HD;
                  nxt.payload_phase = brfp_pkg::PH_DISCARD;
               end else begin
                  kind              = brfp_pkg::KIND_HDR_ID;
                  nxt.name_reg      = (rx_byte == brfp_pkg::ID_CONT_LEN)  ?
                                      brfp_pkg::NAME_CONT_LEN :
                                      (rx_byte == brfp_pkg::ID_CONT_TYPE) ?
                                      brfp_pkg::NAME_CONT_TYPE : brfp_pkg::NAME_UNKNOWN;
                  nxt.payload_phase = brfp_pkg::PH_VL_HI;
               end
            end
            brfp_pkg::PH_VL_HI: begin
               kind              = brfp_pkg::KIND_VAL_LEN;
               nxt.value_left    = {rx_byte, 8'd0};
               nxt.payload_phase = brfp_pkg::PH_VL_LO;
            end
            brfp_pkg::PH_VL_LO: begin
               kind           = brfp_pkg::KIND_VAL_LEN;
               nxt.value_left = vl_full;
               if ({8'd0, vl_full} > pl_m1) begin
                  nxt.pending_error = brfp_pkg::ERR_TRUNC_VL;
                  nxt.payload_phase = brfp_pkg::PH_DISCARD;
               end else if (vl_full == 16'd0) begin
                  nxt.headers_left  = hl_m1;
                  nxt.payload_phase = (hl_m1 != 8'd0) ? brfp_pkg::PH_ID : brfp_pkg::PH_BODY;
               end else begin
                  nxt.payload_phase = brfp_pkg::PH_VALUE;
               end
            end
            brfp_pkg::PH_VALUE: begin
               kind           = brfp_pkg::KIND_VALUE;
               nxt.value_left = vl_m1;
               if (vl_m1 == 16'd0) begin
                  nxt.headers_left  = hl_m1;
                  nxt.payload_phase = (hl_m1 != 8'd0) ? brfp_pkg::PH_ID : brfp_pkg::PH_BODY;
               end
            end
            brfp_pkg::PH_BODY: begin
               kind = brfp_pkg::KIND_BODY;
            end
            brfp_pkg::PH_ERRPAY: begin
               kind = brfp_pkg::KIND_ERR_PAY;
            end
            default: begin
               kind              = brfp_pkg::KIND_DISCARD;
               nxt.payload_phase = brfp_pkg::PH_DISCARD;
            end
         endcase

         nxt.payload_left = pl_m1;
         if (pl_m1 == 24'd0) begin
            // frame ends while entries are still owed
            if (nxt.payload_phase == brfp_pkg::PH_ID &&
                nxt.pending_error == brfp_pkg::ERR_NONE) begin
               nxt.pending_error = brfp_pkg::ERR_TRUNC_HD;
            end
            last                = 1'b1;
            err                 = nxt.pending_error;
            esm                 = (nxt.pending_error != brfp_pkg::ERR_STREAM) &&
                                  !cur.flags_reg[0];
            nxt.header_position = 4'd0;
            nxt.payload_phase   = brfp_pkg::PH_ST_HI;
         end
      end

      res.byte_kind          = kind;
      res.data_byte          = rx_byte;
      res.header_name        = (kind == brfp_pkg::KIND_HDR_ID || kind == brfp_pkg::KIND_VAL_LEN ||
                                kind == brfp_pkg::KIND_VALUE) ? nxt.name_reg : 2'd0;
      res.status_code        = nxt.status_reg;
      res.frame_kind         = nxt.type_reg;
      res.frame_stream       = nxt.stream_reg;
      res.last_of_frame      = last;
      res.error_code         = err;
      res.end_stream_missing = esm;
   end

endmodule

@@ src/binary_response_frame_parser_core.sv @@
// Top level of the binary response frame parser: handshake, CSR and result register.
//
//   channel  | direction | handshake        | payload
//   ---------+-----------+------------------+----------------------------------------
//   req      | in        | req_valid/ready  | req_rx_byte
//   rsp      | out       | rsp_valid/ready  | rsp_byte_kind ... rsp_end_stream_missing
//   csr      | in/out    | psel/penable     | paddr, pwdata, prdata (expected_stream)
//
// One word in, one word out, one word per cycle while rsp_ready is high. Each
// word is classified by the combinational step logic and captured in the result
// register at the edge that accepts it; the result is offered the next cycle.
// req_ready drops only while the result register is full and rsp_ready is low.
// Synchronous reset clears the parser state, empties the result register and
// sets expected_stream to 1.
module binary_response_frame_parser_core (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_byte_kind,
   output logic [7:0]  rsp_data_byte,
   output logic [1:0]  rsp_header_name,
   output logic [15:0] rsp_status_code,
   output logic [7:0]  rsp_frame_kind,
   output logic [31:0] rsp_frame_stream,
   output logic        rsp_last_of_frame,
   output logic [2:0]  rsp_error_code,
   output logic        rsp_end_stream_missing,

   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

`include "binary_response_frame_parser_core_macros.svh"

   // parser state, stepped once per accepted word
   brfp_pkg::state_type  state_ff;
   brfp_pkg::state_type  state_in;
   // result register, one deep; its valid bit gates req_ready
   brfp_pkg::result_type result_ff;
   brfp_pkg::result_type result_in;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   // expected stream id, APB writable
   logic [31:0]          exp_stream_ff;
   logic [31:0]          exp_stream_in;

   logic                 req_fire;
   logic                 csr_wr;

   // terms used by the checks below
   logic                 pos_ok;
   logic                 esm_word;
   logic                 halt_word;
   logic                 hdr_word;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   brfp_step u_step (
      .cur             (state_ff),
      .expected_stream (exp_stream_ff),
      .rx_byte         (req_rx_byte),
      .nxt             (state_in),
      .res             (result_in)
   );

   // result register: loads on every accepted word, drains on rsp handshake
   always_comb begin
      if (req_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_fire) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         result_ff <= result_in;
      end
   end

   // CSR port: always ready, one register at byte address 0
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready && (paddr == brfp_pkg::CSR_EXP_STREAM);
   assign exp_stream_in = csr_wr ? pwdata : exp_stream_ff;
   assign prdata = (paddr == brfp_pkg::CSR_EXP_STREAM) ? exp_stream_ff : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_stream_ff <= 32'd1;
      end else begin
         exp_stream_ff <= exp_stream_in;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_byte_kind          = result_ff.byte_kind;
   assign rsp_data_byte          = result_ff.data_byte;
   assign rsp_header_name        = result_ff.header_name;
   assign rsp_status_code        = result_ff.status_code;
   assign rsp_frame_kind         = result_ff.frame_kind;
   assign rsp_frame_stream       = result_ff.frame_stream;
   assign rsp_last_of_frame      = result_ff.last_of_frame;
   assign rsp_error_code         = result_ff.error_code;
   assign rsp_end_stream_missing = result_ff.end_stream_missing;

   assign pos_ok    = state_ff.header_position <= brfp_pkg::HDR_BYTES;
   assign esm_word  = rsp_valid_ff && result_ff.end_stream_missing;
   assign halt_word = rsp_valid_ff && result_ff.last_of_frame &&
                      (result_ff.error_code == brfp_pkg::ERR_MAGIC ||
                       result_ff.error_code == brfp_pkg::ERR_VERSION);
   assign hdr_word  = result_ff.byte_kind == brfp_pkg::KIND_HEADER;

   // halt is sticky until reset
   `BRFP_ASSERT_NXT(a_halt_sticky, state_ff.halted, state_ff.halted, "halt released")
   // every accepted word yields a result next cycle
   `BRFP_ASSERT_NXT(a_word_to_rsp, req_fire, rsp_valid_ff, "accepted word gave no result")
   // header position never runs past the payload marker
   `BRFP_ASSERT_IMP(a_pos_range, 1'b1, pos_ok, "header position out of range")
   // end-of-stream warning only on a frame's final word
   `BRFP_ASSERT_IMP(a_esm_last, esm_word, result_ff.last_of_frame, "warning off frame end")
   // magic/version failure is reported on a header word
   `BRFP_ASSERT_IMP(a_halt_kind, halt_word, hdr_word, "halting word not a header word")

endmodule
